// File: rtl/core/fmd_pkg.sv
// ============================================================================
// fmd_pkg: shared types and tables of the fractionated Morse decipher
// Beat formats, configuration bundle, symbol codes and the Morse code table.
// ============================================================================
package fmd_pkg;

  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Symbol codes of the ternary expansion.
  localparam logic [1:0] SYM_DOT  = 2'd0;
  localparam logic [1:0] SYM_DASH = 2'd1;
  localparam logic [1:0] SYM_SEP  = 2'd2;
  localparam logic [1:0] SYM_IDLE = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_KEY_LOW = 2'd0;
  localparam logic [1:0] REG_KEY_MID = 2'd1;
  localparam logic [1:0] REG_KEY_TOP = 2'd2;
  localparam logic [1:0] REG_FILLER  = 2'd3;

  localparam int KEY_LEN = 26;

  typedef logic [KEY_LEN-1:0][4:0] key_t;

  typedef struct packed {
    key_t       key;
    logic [4:0] filler;
  } cfg_t;

  // Three symbols, syms[2] is the most significant one.
  typedef struct packed {
    logic [2:0][1:0] syms;
    logic            last;
  } item_t;

  typedef struct packed {
    logic             has_token;
    logic [4:0]       letter;
    logic             valid;
    logic [CNT_W-1:0] tokens;
    logic [CNT_W-1:0] valids;
    logic             fin;
  } res_t;

  // Rank 0..26 to three base-3 digits, most significant digit first.
  function automatic logic [2:0][1:0] rank_syms(input logic [4:0] rank);
    logic [1:0] d0;
    logic [1:0] d1;
    logic [4:0] rem;
    logic [4:0] rem2;
    d0   = (rank >= 5'd18) ? 2'd2 : ((rank >= 5'd9) ? 2'd1 : 2'd0);
    rem  = rank - ((d0 == 2'd2) ? 5'd18 : ((d0 == 2'd1) ? 5'd9 : 5'd0));
    d1   = (rem >= 5'd6) ? 2'd2 : ((rem >= 5'd3) ? 2'd1 : 2'd0);
    rem2 = rem - ((d1 == 2'd2) ? 5'd6 : ((d1 == 2'd1) ? 5'd3 : 5'd0));
    return {d0, d1, rem2[1:0]};
  endfunction

  // Code word (leading one, dash = 1) to {legal, letter}.
  function automatic logic [5:0] morse_lookup(input logic [4:0] code);
    logic [5:0] r;
    case (code)
      5'd2:    r = {1'b1, 5'd4};
      5'd3:    r = {1'b1, 5'd19};
      5'd4:    r = {1'b1, 5'd8};
      5'd5:    r = {1'b1, 5'd0};
      5'd6:    r = {1'b1, 5'd13};
      5'd7:    r = {1'b1, 5'd12};
      5'd8:    r = {1'b1, 5'd18};
      5'd9:    r = {1'b1, 5'd20};
      5'd10:   r = {1'b1, 5'd17};
      5'd11:   r = {1'b1, 5'd22};
      5'd12:   r = {1'b1, 5'd3};
      5'd13:   r = {1'b1, 5'd10};
      5'd14:   r = {1'b1, 5'd6};
      5'd15:   r = {1'b1, 5'd14};
      5'd16:   r = {1'b1, 5'd7};
      5'd17:   r = {1'b1, 5'd21};
      5'd18:   r = {1'b1, 5'd5};
      5'd20:   r = {1'b1, 5'd11};
      5'd22:   r = {1'b1, 5'd15};
      5'd23:   r = {1'b1, 5'd9};
      5'd24:   r = {1'b1, 5'd1};
      5'd25:   r = {1'b1, 5'd23};
      5'd26:   r = {1'b1, 5'd2};
      5'd27:   r = {1'b1, 5'd24};
      5'd28:   r = {1'b1, 5'd25};
      5'd29:   r = {1'b1, 5'd16};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/fmd_regs.sv
// ============================================================================
// fmd_regs: configuration register file
// APB-style write and read of the keyed alphabet and the filler letter.
// ============================================================================
module fmd_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output fmd_pkg::cfg_t cfg
);

  logic [59:0] low_r;
  logic [59:0] mid_r;
  logic [9:0]  top_r;
  logic [4:0]  fill_r;
  logic [1:0]  idx;
  logic        wr_en;

  assign idx   = paddr[4:3];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      mid_r  <= '0;
      top_r  <= '0;
      fill_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        fmd_pkg::REG_KEY_LOW: low_r  <= pwdata[59:0];
        fmd_pkg::REG_KEY_MID: mid_r  <= pwdata[59:0];
        fmd_pkg::REG_KEY_TOP: top_r  <= pwdata[9:0];
        fmd_pkg::REG_FILLER:  fill_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fmd_pkg::REG_KEY_LOW: prdata = {4'd0, low_r};
      fmd_pkg::REG_KEY_MID: prdata = {4'd0, mid_r};
      fmd_pkg::REG_KEY_TOP: prdata = {54'd0, top_r};
      fmd_pkg::REG_FILLER:  prdata = {59'd0, fill_r};
      default:              prdata = '0;
    endcase
  end

  assign cfg.key    = {top_r, mid_r, low_r};
  assign cfg.filler = fill_r;

endmodule

// File: rtl/core/fmd_front.sv
// ============================================================================
// fmd_front: letter classification
// Matches a ciphertext letter against the keyed alphabet and expands its rank
// into three Morse symbols.
// ============================================================================
module fmd_front (
  input  logic           in_valid,
  input  logic           in_stall,
  input  logic [4:0]     in_cipher_letter,
  input  logic           in_message_end,
  input  fmd_pkg::key_t  key,
  output logic           push,
  output fmd_pkg::item_t item
);

  logic [4:0] rank;

  // The highest matching position wins; no match gives rank 26.
  always_comb begin
    rank = 5'd26;
    for (int r = 0; r < fmd_pkg::KEY_LEN; r++) begin
      if (key[r] == in_cipher_letter) begin
        rank = 5'(r);
      end
    end
  end

  assign item.syms = fmd_pkg::rank_syms(rank);
  assign item.last = in_message_end;
  assign push      = in_valid && !in_stall;

endmodule

// File: rtl/core/fmd_item_q.sv
// ============================================================================
// fmd_item_q: two-entry queue between front and back
// Holds classified letters so that either side can stall on its own.
// ============================================================================
module fmd_item_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fmd_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output fmd_pkg::item_t head
);

  fmd_pkg::item_t ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/fmd_back.sv
// ============================================================================
// fmd_back: run accumulation and token output
// Walks the three symbols of a letter, closes runs, counts tokens and queues
// up to two results per letter for the output channel.
// ============================================================================
module fmd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  fmd_pkg::item_t item,
  input  logic [4:0]     filler,
  output logic           item_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output fmd_pkg::res_t  out_res
);

  localparam logic [fmd_pkg::CNT_W-1:0] CNT_ONE = fmd_pkg::CNT_W'(1);

  logic [2:0]                run_len_r;
  logic [4:0]                code_r;
  logic [fmd_pkg::CNT_W-1:0] tok_r;
  logic [fmd_pkg::CNT_W-1:0] val_r;

  logic [2:0]                rl;
  logic [4:0]                cv;
  logic [fmd_pkg::CNT_W-1:0] tk;
  logic [fmd_pkg::CNT_W-1:0] vk;
  logic [3:0][1:0]           seq;
  logic [1:0]                s;
  logic [5:0]                lk;
  logic                      ok;
  logic [1:0]                n;
  fmd_pkg::res_t             cur;
  fmd_pkg::res_t             r0;
  fmd_pkg::res_t             r1;

  fmd_pkg::res_t             fifo_r [4];
  logic [1:0]                wr_ptr_r;
  logic [1:0]                rd_ptr_r;
  logic [2:0]                cnt_r;
  logic [2:0]                cnt_nxt;
  logic                      out_pop;

  // The end of the message acts as a fourth separator.
  always_comb begin
    rl  = run_len_r;
    cv  = code_r;
    tk  = tok_r;
    vk  = val_r;
    n   = 2'd0;
    r0  = '0;
    r1  = '0;
    lk  = '0;
    ok  = 1'b0;
    cur = '0;
    seq = {item.syms, item.last ? fmd_pkg::SYM_SEP : fmd_pkg::SYM_IDLE};
    s   = fmd_pkg::SYM_IDLE;
    for (int i = 0; i < 4; i++) begin
      s = seq[2'(3 - i)];
      if (s == fmd_pkg::SYM_SEP) begin
        if (rl != 3'd0) begin
          lk = fmd_pkg::morse_lookup(cv);
          ok = lk[5] && (rl <= 3'd4);
          if (tk != fmd_pkg::COUNT_MAX) tk = tk + CNT_ONE;
          if (ok && (vk != fmd_pkg::COUNT_MAX)) vk = vk + CNT_ONE;
          cur.has_token = 1'b1;
          cur.letter    = ok ? lk[4:0] : filler;
          cur.valid     = ok;
          cur.tokens    = tk;
          cur.valids    = vk;
          cur.fin       = 1'b0;
          if (n == 2'd0) r0 = cur;
          else           r1 = cur;
          n = n + 2'd1;
        end
        rl = 3'd0;
        cv = 5'd1;
      end else if (s != fmd_pkg::SYM_IDLE) begin
        if (rl < 3'd4) cv = {cv[3:0], s[0]};
        if (rl < 3'd5) rl = rl + 3'd1;
      end
    end
    if (item.last) begin
      if (n == 2'd0) begin
        r0.tokens = tk;
        r0.valids = vk;
        r0.fin    = 1'b1;
        n = 2'd1;
      end else if (n == 2'd1) begin
        r0.fin = 1'b1;
      end else begin
        r1.fin = 1'b1;
      end
      tk = '0;
      vk = '0;
    end
  end

  // A letter leaves the queue only when two result slots are free.
  assign item_pop  = item_valid && (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = fifo_r[rd_ptr_r];
  assign out_pop   = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r + (item_pop ? {1'b0, n} : 3'd0) - {2'd0, out_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r <= 3'd0;
      code_r    <= 5'd1;
      tok_r     <= '0;
      val_r     <= '0;
      wr_ptr_r  <= 2'd0;
      rd_ptr_r  <= 2'd0;
      cnt_r     <= 3'd0;
    end else begin
      if (item_pop) begin
        run_len_r <= rl;
        code_r    <= cv;
        tok_r     <= tk;
        val_r     <= vk;
        wr_ptr_r  <= wr_ptr_r + n;
      end
      if (out_pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && (n != 2'd0)) begin
      fifo_r[wr_ptr_r] <= r0;
    end
    if (item_pop && (n == 2'd2)) begin
      fifo_r[wr_ptr_r + 2'd1] <= r1;
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> cnt_r <= 3'd2)
    else $error("letter taken without room for two results");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (item_pop && item.last) |=> (tok_r == '0) && (val_r == '0) && (run_len_r == 3'd0))
    else $error("message end did not clear the counts");

  a_final_made: assert property (@(posedge clk) disable iff (!rst_n)
    (item_pop && item.last) |-> (n != 2'd0) && ((n == 2'd1) ? r0.fin : r1.fin))
    else $error("message end produced no final result");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.valids <= out_res.tokens)
    else $error("valid count above token count");

endmodule

// File: rtl/core/fractionated_morse_decipher.sv
// ============================================================================
// fractionated_morse_decipher: fractionated Morse cipher decryption
// Turns ciphertext letters into decoded Morse letters with running counts.
// ============================================================================
// Usage: one ciphertext letter is a beat on the in_ channel (in_valid, in_stall);
// each decoded token, or the closing beat of a message, is a beat on the out_
// channel (out_valid, out_stall). A letter yields zero, one or two result beats;
// the letter flagged by in_message_end always yields at least one, and its last
// result carries out_is_final. The keyed alphabet and filler letter are set
// through the APB-style port at byte addresses 0, 8, 16 and 24; the user must
// write them only while idle, as the block itself does not enforce it. A taken
// letter passes through the item queue and then the result queue before it
// leaves as a result beat. Throughput: one letter per cycle while the result
// queue has room; the four-entry result queue absorbs a letter's two tokens.
// The back end takes a letter only while two result slots are free, so a
// stalled receiver fills the result queue, then the item queue, and then
// raises in_stall. Results wait in the queue unchanged while out_stall is high.
// Reset (rst_n low at a clock edge) empties both queues, clears the run and
// the counts and zeroes all configuration registers.
// ============================================================================
module fractionated_morse_decipher (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Ciphertext channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_cipher_letter,
  input  logic        in_message_end,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_token,
  output logic [4:0]  out_token_letter,
  output logic        out_token_valid,
  output logic [10:0] out_tokens_so_far,
  output logic [10:0] out_valid_so_far,
  output logic        out_is_final
);

  fmd_pkg::cfg_t  cfg;
  fmd_pkg::item_t front_item;
  fmd_pkg::item_t head_item;
  fmd_pkg::res_t  res;
  logic           push;
  logic           full;
  logic           head_valid;
  logic           item_pop;

  // The register file never inserts wait states.
  assign pready = 1'b1;

  fmd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The front end stalls only when the item queue is full, which depends on
  // registered state alone.
  assign in_stall = full;

  fmd_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cipher_letter (in_cipher_letter),
    .in_message_end   (in_message_end),
    .key              (cfg.key),
    .push             (push),
    .item             (front_item)
  );

  fmd_item_q u_item_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (front_item),
    .pop        (item_pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head_item)
  );

  fmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (head_valid),
    .item       (head_item),
    .filler     (cfg.filler),
    .item_pop   (item_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_has_token     = res.has_token;
  assign out_token_letter  = res.letter;
  assign out_token_valid   = res.valid;
  assign out_tokens_so_far = res.tokens;
  assign out_valid_so_far  = res.valids;
  assign out_is_final      = res.fin;

endmodule
